@@ rtl/core/ifp_pkg.sv @@
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared types, constants and decode helpers for the IMU frame parser.
// ----------------------------------------------------------------------------
package ifp_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 16;
    localparam int MUL_W       = 17;
    localparam int VALUE_W     = 32;
    localparam int PROD_W      = RAW_W + MUL_W + 1;
    localparam int SCALE_SHIFT = 8;
    localparam int NUM_VALUES  = 4;
    localparam int VIDX_W      = $clog2(NUM_VALUES);

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;

    localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h51;
    localparam logic [BYTE_W-1:0] TYPE_GYRO  = 8'h52;
    localparam logic [BYTE_W-1:0] TYPE_QUAT  = 8'h59;

    localparam logic [MUL_W-1:0] MUL_ACCEL = 17'd80336;
    localparam logic [MUL_W-1:0] MUL_GYRO  = 17'd17872;
    localparam logic [MUL_W-1:0] MUL_QUAT  = 17'd512;

    // first raw value sits right after header and type bytes
    localparam logic [IDX_W-1:0] RAW_FIRST = IDX_W'(2);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        KIND_ACCEL   = 2'd0,
        KIND_GYRO    = 2'd1,
        KIND_QUAT    = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_SUM   = 7'b000_0010,
        ST_SCAN  = 7'b000_0100,
        ST_SHIFT = 7'b000_1000,
        ST_LO    = 7'b001_0000,
        ST_HI    = 7'b010_0000,
        ST_PUB   = 7'b100_0000
    } state_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [BYTE_W-1:0]  data;
    } store_wr_t;

    function automatic kind_t kind_of(input logic [BYTE_W-1:0] type_b);
        kind_t k;
        case (type_b)
            TYPE_ACCEL: k = KIND_ACCEL;
            TYPE_GYRO:  k = KIND_GYRO;
            TYPE_QUAT:  k = KIND_QUAT;
            default:    k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [MUL_W-1:0] mul_of(input kind_t k);
        logic [MUL_W-1:0] m;
        case (k)
            KIND_ACCEL: m = MUL_ACCEL;
            KIND_GYRO:  m = MUL_GYRO;
            KIND_QUAT:  m = MUL_QUAT;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/imu_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// imu_frame_parser_unit
// Serial IMU frame parser with 8-bit sum checksum and fixed-point scaling.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one received byte per item. While
// no frame is open, bytes other than the header byte are dropped. Bytes that
// do not complete a frame leave in_ready high, so further bytes are taken
// until a frame completes. The byte that completes an 11-byte frame starts
// the sequencer, which walks the frame store through its single registered
// read port, first for the checksum. A bad frame then scans for the next
// header byte and moves the tail down, one byte per cycle, or drops the frame
// when no header byte follows. A good frame runs each raw value through the
// one shared multiplier (3 or 4 values, none for an unknown type), then
// catches the last product, if any, and publishes the result. For the
// completing byte, in_ready is low after the accepting cycle until the
// sequencer is back in idle.
// Output channel out_valid/out_ready holds one result item in a register;
// further bytes are taken while it waits. Only a second finished frame
// stalls, in the publish step, until the receiver takes the first.
// Reset: header byte 0x55, frame store empty, no result pending.
// The user must write the header byte via cfg_wr_en/cfg_wr_data only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module imu_frame_parser_unit
    import ifp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic        [BYTE_W-1:0]   cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic        [BYTE_W-1:0]   byte_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic        [1:0]          frame_kind,
    output logic        [BYTE_W-1:0]   type_byte,
    output logic signed [VALUE_W-1:0]  value_a,
    output logic signed [VALUE_W-1:0]  value_b,
    output logic signed [VALUE_W-1:0]  value_c,
    output logic signed [VALUE_W-1:0]  value_d
);

    state_t                     state_reg, state_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           sh_reg, sh_next;
    logic [VIDX_W-1:0]          vidx_reg, vidx_next;
    logic [BYTE_W-1:0]          header_reg;
    logic [BYTE_W-1:0]          sum_reg, sum_next;
    logic [BYTE_W-1:0]          type_reg, type_next;
    logic [BYTE_W-1:0]          lo_reg, lo_next;
    kind_t                      kind_reg, kind_next;
    logic                       cap_reg, cap_next;
    logic signed [VALUE_W-1:0]  stage_reg [NUM_VALUES];
    logic signed [VALUE_W-1:0]  stage_next [NUM_VALUES];

    logic                       out_valid_reg;
    kind_t                      out_kind_reg;
    logic [BYTE_W-1:0]          out_type_reg;
    logic signed [VALUE_W-1:0]  out_val_reg [NUM_VALUES];

    store_wr_t                  st_wr;
    logic [IDX_W-1:0]           rd_addr;
    logic [BYTE_W-1:0]          rd_data;
    logic                       mul_start;
    logic signed [VALUE_W-1:0]  mul_result;
    logic                       in_take;
    logic                       publish;
    logic [VIDX_W-1:0]          vidx_last;

    ifp_frame_store u_store (
        .clk     (clk),
        .wr      (st_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ifp_scaler u_scaler (
        .clk    (clk),
        .start  (mul_start),
        .raw    ($signed({rd_data, lo_reg})),
        .mul    (mul_of(kind_reg)),
        .result (mul_result)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign publish   = (state_reg == ST_PUB) && !cap_reg && (!out_valid_reg || out_ready);
    assign vidx_last = (kind_reg == KIND_QUAT) ? VIDX_W'(NUM_VALUES - 1)
                                               : VIDX_W'(NUM_VALUES - 2);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        sh_next    = sh_reg;
        vidx_next  = vidx_reg;
        sum_next   = sum_reg;
        type_next  = type_reg;
        lo_next    = lo_reg;
        kind_next  = kind_reg;
        cap_next   = 1'b0;
        stage_next = stage_reg;
        st_wr      = '0;
        mul_start  = 1'b0;

        // value from the previous multiply lands in the cycle after HI
        if (cap_reg)
        begin
            stage_next[vidx_reg] = mul_result;
            vidx_next            = vidx_reg + VIDX_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (fill_reg != '0 || byte_in == header_reg))
                begin
                    st_wr.en   = 1'b1;
                    st_wr.addr = fill_reg[IDX_W-1:0];
                    st_wr.data = byte_in;
                    fill_next  = fill_reg + FILL_W'(1);
                    if (fill_reg == FILL_W'(FRAME_BYTES - 1))
                    begin
                        state_next = ST_SUM;
                        idx_next   = '0;
                        sum_next   = '0;
                    end
                end
            end
            ST_SUM:
            begin
                if (idx_reg == IDX_W'(1))
                begin
                    type_next = rd_data;
                end
                if (idx_reg != LAST_IDX)
                begin
                    sum_next = sum_reg + rd_data;
                    idx_next = idx_reg + IDX_W'(1);
                end
                else if (sum_reg == rd_data)
                begin
                    kind_next = kind_of(type_reg);
                    for (int v = 0; v < NUM_VALUES; v++)
                    begin
                        stage_next[v] = '0;
                    end
                    vidx_next = '0;
                    idx_next  = RAW_FIRST;
                    if (kind_of(type_reg) == KIND_UNKNOWN)
                    begin
                        state_next = ST_PUB;
                    end
                    else
                    begin
                        state_next = ST_LO;
                    end
                end
                else
                begin
                    idx_next   = IDX_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_data == header_reg)
                begin
                    sh_next    = idx_reg;
                    idx_next   = '0;
                    state_next = ST_SHIFT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SHIFT:
            begin
                st_wr.en   = 1'b1;
                st_wr.addr = idx_reg;
                st_wr.data = rd_data;
                if (idx_reg + sh_reg == LAST_IDX)
                begin
                    fill_next  = FILL_W'(FRAME_BYTES) - FILL_W'(sh_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_LO:
            begin
                lo_next    = rd_data;
                idx_next   = idx_reg + IDX_W'(1);
                state_next = ST_HI;
            end
            ST_HI:
            begin
                mul_start = 1'b1;
                cap_next  = 1'b1;
                idx_next  = idx_reg + IDX_W'(1);
                if (vidx_reg == vidx_last)
                begin
                    state_next = ST_PUB;
                end
                else
                begin
                    state_next = ST_LO;
                end
            end
            ST_PUB:
            begin
                if (publish)
                begin
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // store read is registered: present the address for the next cycle
        if (state_next == ST_SHIFT)
        begin
            rd_addr = idx_next + sh_next;
        end
        else
        begin
            rd_addr = idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            header_reg    <= HEADER_RESET;
            cap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cap_reg   <= cap_next;
            if (cfg_wr_en)
            begin
                header_reg <= cfg_wr_data;
            end
            if (publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        sh_reg    <= sh_next;
        vidx_reg  <= vidx_next;
        sum_reg   <= sum_next;
        type_reg  <= type_next;
        lo_reg    <= lo_next;
        kind_reg  <= kind_next;
        stage_reg <= stage_next;
        if (publish)
        begin
            out_kind_reg <= kind_reg;
            out_type_reg <= type_reg;
            out_val_reg  <= stage_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_kind = out_kind_reg;
    assign type_byte  = out_type_reg;
    assign value_a    = out_val_reg[0];
    assign value_b    = out_val_reg[1];
    assign value_c    = out_val_reg[2];
    assign value_d    = out_val_reg[3];

    // fill count never passes the frame length, and is below it while idle
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= FILL_W'(FRAME_BYTES)))
        else $error("fill count beyond frame length");

    a_idle_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (fill_reg < FILL_W'(FRAME_BYTES)))
        else $error("idle with a full frame held");

    // the completing byte starts the checksum walk
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && fill_reg == FILL_W'(FRAME_BYTES - 1)) |=> (state_reg == ST_SUM))
        else $error("full frame did not start checksum");

    // unknown frame types publish all-zero values
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_UNKNOWN) |->
        (value_a == '0 && value_b == '0 && value_c == '0 && value_d == '0))
        else $error("unknown frame type with nonzero values");

    // a publish never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_type_reg))
        else $error("pending result overwritten");

endmodule

@@ rtl/core/ifp_frame_store.sv @@
// ----------------------------------------------------------------------------
// ifp_frame_store
// Byte store for one frame: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ifp_frame_store
    import ifp_pkg::*;
(
    input  logic               clk,
    input  store_wr_t          wr,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [BYTE_W-1:0]  rd_data
);

    logic [BYTE_W-1:0] store_mem [FRAME_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
        rd_data <= store_mem[rd_addr];
    end

endmodule

@@ rtl/core/ifp_scaler.sv @@
// ----------------------------------------------------------------------------
// ifp_scaler
// Shared multiplier: signed raw sample times unit constant, floor shift by 8.
// ----------------------------------------------------------------------------
module ifp_scaler
    import ifp_pkg::*;
(
    input  logic                       clk,
    input  logic                       start,
    input  logic signed [RAW_W-1:0]    raw,
    input  logic        [MUL_W-1:0]    mul,
    output logic signed [VALUE_W-1:0]  result
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] shifted;

    assign prod_next = PROD_W'(raw) * $signed({1'b0, mul});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_next;
        end
    end

    assign shifted = prod_reg >>> SCALE_SHIFT;
    assign result  = shifted[VALUE_W-1:0];

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu frame parser testbench
// Sends header-led frames with random payloads, broken checksums, resync
// sequences and line noise into the parser under four header settings and
// three flow-control mixes. Every accepted byte goes through a local copy of
// the frame store; each finished frame is compared field by field with the
// result item that the parser hands out.
// ----------------------------------------------------------------------------
module tb;
    import ifp_pkg::*;

    typedef logic [BYTE_W-1:0] frame_bytes_t [FRAME_BYTES];

    typedef struct {
        kind_t                     kind;
        logic [BYTE_W-1:0]         typ;
        logic signed [VALUE_W-1:0] va;
        logic signed [VALUE_W-1:0] vb;
        logic signed [VALUE_W-1:0] vc;
        logic signed [VALUE_W-1:0] vd;
    } frame_result_t;

    localparam int DRAIN_CYCLES = 40;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [BYTE_W-1:0]         cfg_wr_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [BYTE_W-1:0]         byte_in = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [1:0]                frame_kind;
    logic [BYTE_W-1:0]         type_byte;
    logic signed [VALUE_W-1:0] value_a;
    logic signed [VALUE_W-1:0] value_b;
    logic signed [VALUE_W-1:0] value_c;
    logic signed [VALUE_W-1:0] value_d;

    logic [BYTE_W-1:0] pending_bytes [$];
    frame_result_t     expected_frames [$];
    int                queued_count = 0;
    int                mismatch_count = 0;
    int                send_idle_pct = 20;
    int                recv_idle_pct = 48;

    // local copy of the parser state
    logic [BYTE_W-1:0] hdr_cfg = HEADER_RESET;
    logic [BYTE_W-1:0] held_bytes [FRAME_BYTES];
    int                held_count = 0;

    imu_frame_parser_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_kind  (frame_kind),
        .type_byte   (type_byte),
        .value_a     (value_a),
        .value_b     (value_b),
        .value_c     (value_c),
        .value_d     (value_d)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic signed [VALUE_W-1:0] to_q16(input logic [BYTE_W-1:0] lo,
                                                        input logic [BYTE_W-1:0] hi,
                                                        input logic [MUL_W-1:0] mul);
        longint p;
        p = longint'($signed({hi, lo})) * longint'(mul);
        return VALUE_W'(p >>> SCALE_SHIFT);
    endfunction

    function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] chk;
        logic [MUL_W-1:0]  mul;
        frame_result_t     r;
        int                i;
        int                j;
        if (held_count == 0 && b != hdr_cfg)
            return;
        if (held_count >= FRAME_BYTES)
            held_count = 0;
        held_bytes[held_count] = b;
        held_count++;
        if (held_count < FRAME_BYTES)
            return;
        chk = '0;
        for (i = 0; i < FRAME_BYTES - 1; i++)
            chk += held_bytes[i];
        if (chk != held_bytes[FRAME_BYTES-1])
        begin
            for (i = 1; i < held_count; i++)
            begin
                if (held_bytes[i] == hdr_cfg)
                begin
                    for (j = 0; j < held_count - i; j++)
                        held_bytes[j] = held_bytes[j+i];
                    held_count = held_count - i;
                    return;
                end
            end
            held_count = 0;
            return;
        end
        r.typ = held_bytes[1];
        case (r.typ)
            TYPE_ACCEL: begin r.kind = KIND_ACCEL;   mul = MUL_ACCEL; end
            TYPE_GYRO:  begin r.kind = KIND_GYRO;    mul = MUL_GYRO;  end
            TYPE_QUAT:  begin r.kind = KIND_QUAT;    mul = MUL_QUAT;  end
            default:    begin r.kind = KIND_UNKNOWN; mul = '0;        end
        endcase
        r.va = '0;
        r.vb = '0;
        r.vc = '0;
        r.vd = '0;
        if (r.kind != KIND_UNKNOWN)
        begin
            r.va = to_q16(held_bytes[2], held_bytes[3], mul);
            r.vb = to_q16(held_bytes[4], held_bytes[5], mul);
            r.vc = to_q16(held_bytes[6], held_bytes[7], mul);
            if (r.kind == KIND_QUAT)
                r.vd = to_q16(held_bytes[8], held_bytes[9], mul);
        end
        expected_frames.push_back(r);
        held_count = 0;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            byte_in  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_byte(byte_in);
            if (!in_valid || in_ready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    byte_in  <= pending_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        frame_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                    flag_mismatch($sformatf("unexpected item type 0x%02h", type_byte));
                else
                begin
                    want = expected_frames.pop_front();
                    if (frame_kind !== want.kind)
                        flag_mismatch($sformatf("frame_kind %0d, want %0d",
                                                frame_kind, want.kind));
                    if (type_byte !== want.typ)
                        flag_mismatch($sformatf("type_byte 0x%02h, want 0x%02h",
                                                type_byte, want.typ));
                    if (value_a !== want.va)
                        flag_mismatch($sformatf("value_a %0d, want %0d", value_a, want.va));
                    if (value_b !== want.vb)
                        flag_mismatch($sformatf("value_b %0d, want %0d", value_b, want.vb));
                    if (value_c !== want.vc)
                        flag_mismatch($sformatf("value_c %0d, want %0d", value_c, want.vc));
                    if (value_d !== want.vd)
                        flag_mismatch($sformatf("value_d %0d, want %0d", value_d, want.vd));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return {hdr_cfg, 8'($urandom)};
            3:       return {8'($urandom), hdr_cfg};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_type();
        case ($urandom_range(4))
            0:       return TYPE_ACCEL;
            1:       return TYPE_GYRO;
            2:       return TYPE_QUAT;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic frame_bytes_t build_frame(input logic [BYTE_W-1:0] typ,
                                                 input logic [4*RAW_W-1:0] raws,
                                                 input bit corrupt);
        frame_bytes_t      f;
        logic [BYTE_W-1:0] chk;
        int                i;
        f[0] = hdr_cfg;
        f[1] = typ;
        for (i = 0; i < 8; i++)
            f[2+i] = raws[8*i +: 8];
        chk = '0;
        for (i = 0; i < FRAME_BYTES - 1; i++)
            chk += f[i];
        f[FRAME_BYTES-1] = corrupt ? chk ^ 8'($urandom_range(255, 1)) : chk;
        return f;
    endfunction

    function automatic logic [4*RAW_W-1:0] random_raws();
        return {pick_raw(), pick_raw(), pick_raw(), pick_raw()};
    endfunction

    function automatic void push_frame(input frame_bytes_t f);
        int i;
        for (i = 0; i < FRAME_BYTES; i++)
            pending_bytes.push_back(f[i]);
        queued_count += FRAME_BYTES;
    endfunction

    // false start of k bytes, then a whole frame that the parser must resync onto
    function automatic void push_split(input int k, input frame_bytes_t f);
        int i;
        pending_bytes.push_back(hdr_cfg);
        for (i = 1; i < k; i++)
            pending_bytes.push_back(8'($urandom));
        queued_count += k;
        push_frame(f);
    endfunction

    task automatic queue_random(input int n_items);
        int goal;
        int sel;
        int i;
        goal = queued_count + n_items;
        while (queued_count < goal)
        begin
            sel = $urandom_range(99);
            if (sel < 55)
                push_frame(build_frame(pick_type(), random_raws(), 1'b0));
            else if (sel < 70)
                push_split($urandom_range(FRAME_BYTES - 1, 1),
                           build_frame(pick_type(), random_raws(), 1'b0));
            else if (sel < 82)
                push_frame(build_frame(pick_type(), random_raws(), 1'b1));
            else if (sel < 92)
            begin
                for (i = $urandom_range(4, 1); i > 0; i--)
                begin
                    pending_bytes.push_back(8'($urandom));
                    queued_count += 1;
                end
            end
            else
            begin
                pending_bytes.push_back(hdr_cfg);
                queued_count += 1;
                for (i = $urandom_range(6, 1); i > 0; i--)
                begin
                    pending_bytes.push_back(8'($urandom));
                    queued_count += 1;
                end
            end
        end
    endtask

    task automatic drain();
        wait (pending_bytes.size() == 0 && !in_valid);
        wait (expected_frames.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_header(input logic [BYTE_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        hdr_cfg = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: noise, every frame kind at the raw extremes, bad sum, resync
        send_idle_pct = 20;
        recv_idle_pct = 48;
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hff);
        pending_bytes.push_back(~hdr_cfg);
        push_frame(build_frame(TYPE_ACCEL, {16'h0001, 16'hffff, 16'h7fff, 16'h8000}, 1'b0));
        push_frame(build_frame(TYPE_GYRO,  {16'h0000, 16'h7fff, 16'h8000, 16'hffff}, 1'b0));
        push_frame(build_frame(TYPE_QUAT,  {16'h1234, 16'h7fff, 16'hffff, 16'h8000}, 1'b0));
        push_frame(build_frame(8'h00, {16'hffff, 16'hffff, 16'hffff, 16'hffff}, 1'b0));
        push_frame(build_frame(8'hff, {16'h8000, 16'h7fff, 16'h0000, 16'h0001}, 1'b0));
        push_frame(build_frame(TYPE_ACCEL, random_raws(), 1'b1));
        push_split(4, build_frame(TYPE_QUAT, {16'hffff, 16'h0001, 16'h8000, 16'h7fff}, 1'b0));
        queue_random(300);
        drain();

        write_header(8'h00);
        send_idle_pct = 48;
        recv_idle_pct = 20;
        queue_random(250);
        drain();

        write_header(8'hff);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(200);
        drain();

        write_header(8'($urandom));
        queue_random(200);
        drain();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
